// ----- rtl/core/bbcd_pkg.sv -----
// package for the binary to bcd digit driver
// holds widths, constants, controller states and command/status types
// no dependencies
`default_nettype none

package bbcd_pkg;

    localparam int VALUE_W    = 32;
    localparam int DIGIT_W    = 4;
    localparam int COUNT_W    = 4;
    localparam int PROD_W     = 2 * VALUE_W;

    localparam logic [COUNT_W-1:0] MAX_DIGITS        = 4'd10;
    localparam logic [COUNT_W-1:0] DIGIT_COUNT_RESET = 4'd3;

    // floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for every 32-bit x
    localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;
    localparam int                 QUOT_W      = PROD_W - RECIP_SHIFT;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic load;   // capture a new value
        logic mul;    // register rest times reciprocal
        logic step;   // emit one digit, advance to the quotient
    } dp_cmd_t;

    typedef struct packed {
        logic last_digit;  // digit about to be emitted is the final one
        logic out_free;    // output register can take a digit this cycle
    } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/bbcd_ctrl.sv -----
// controller state machine for the binary to bcd digit driver
// depends on bbcd_pkg
`default_nettype none

module bbcd_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire bbcd_pkg::dp_status_t status,
    output bbcd_pkg::dp_cmd_t       cmd
);

    bbcd_pkg::ctrl_state_t state_reg;
    bbcd_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bbcd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bbcd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bbcd_pkg::ST_MUL;
                end
            end
            bbcd_pkg::ST_MUL:
            begin
                state_next = bbcd_pkg::ST_EMIT;
            end
            bbcd_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = status.last_digit ? bbcd_pkg::ST_IDLE : bbcd_pkg::ST_MUL;
                end
            end
            default:
            begin
                state_next = bbcd_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            bbcd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            bbcd_pkg::ST_MUL:
            begin
                cmd.mul = 1'b1;
            end
            bbcd_pkg::ST_EMIT:
            begin
                cmd.step = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/bbcd_datapath.sv -----
// datapath for the binary to bcd digit driver: digit count register,
// divide-by-ten through a reciprocal multiply, output register
// depends on bbcd_pkg
`default_nettype none

module bbcd_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire bbcd_pkg::dp_cmd_t               cmd,
    output bbcd_pkg::dp_status_t                 status,
    input  wire logic                            cfg_valid,
    input  wire logic [bbcd_pkg::COUNT_W-1:0]    cfg_data,
    input  wire logic [bbcd_pkg::VALUE_W-1:0]    value,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [bbcd_pkg::COUNT_W-1:0]         digit_select,
    output logic [bbcd_pkg::DIGIT_W-1:0]         bcd_digit,
    output logic                                 last
);

    logic [bbcd_pkg::COUNT_W-1:0] count_reg;
    logic [bbcd_pkg::COUNT_W-1:0] eff_count;
    logic [bbcd_pkg::COUNT_W-1:0] n_reg;
    logic [bbcd_pkg::COUNT_W-1:0] k_reg;
    logic [bbcd_pkg::VALUE_W-1:0] rest_reg;
    logic [bbcd_pkg::PROD_W-1:0]  prod_reg;
    logic [bbcd_pkg::PROD_W-1:0]  prod_next;
    logic [bbcd_pkg::VALUE_W-1:0] quot;
    logic [bbcd_pkg::VALUE_W-1:0] quot_x10;
    logic [bbcd_pkg::VALUE_W-1:0] remainder;
    logic                         out_valid_reg;
    logic [bbcd_pkg::COUNT_W-1:0] sel_reg;
    logic [bbcd_pkg::DIGIT_W-1:0] bcd_reg;
    logic                         last_reg;

    // digit count register, zero counts as one, saturates at the maximum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= bbcd_pkg::DIGIT_COUNT_RESET;
        end
        else if (cfg_valid)
        begin
            count_reg <= cfg_data;
        end
    end

    always_comb
    begin
        eff_count = count_reg;
        if (count_reg == '0)
        begin
            eff_count = bbcd_pkg::COUNT_W'(1);
        end
        else if (count_reg > bbcd_pkg::MAX_DIGITS)
        begin
            eff_count = bbcd_pkg::MAX_DIGITS;
        end
    end

    assign prod_next = bbcd_pkg::PROD_W'(rest_reg) * bbcd_pkg::PROD_W'(bbcd_pkg::RECIP_10);
    assign quot      = bbcd_pkg::VALUE_W'(prod_reg[bbcd_pkg::PROD_W-1:bbcd_pkg::RECIP_SHIFT]);
    assign quot_x10  = {quot[bbcd_pkg::VALUE_W-4:0], 3'b000} + {quot[bbcd_pkg::VALUE_W-2:0], 1'b0};
    assign remainder = rest_reg - quot_x10;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rest_reg <= value;
            n_reg    <= eff_count;
            k_reg    <= '0;
        end
        else if (cmd.step)
        begin
            rest_reg <= quot;
            k_reg    <= k_reg + bbcd_pkg::COUNT_W'(1);
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
        end
    end

    assign status.last_digit = (k_reg + bbcd_pkg::COUNT_W'(1)) == n_reg;
    assign status.out_free   = !out_valid_reg || out_ready;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            sel_reg  <= k_reg;
            bcd_reg  <= remainder[bbcd_pkg::DIGIT_W-1:0];
            last_reg <= status.last_digit;
        end
    end

    assign out_valid    = out_valid_reg;
    assign digit_select = sel_reg;
    assign bcd_digit    = bcd_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

// ----- rtl/core/binary_to_bcd_digit_driver_core.sv -----
// top level of the binary to bcd digit driver
// instantiates bbcd_ctrl and bbcd_datapath, uses bbcd_pkg
`default_nettype none

// usage
//   input channel (in_valid/in_ready, value): one 32-bit unsigned request
//   per value to display. output channel (out_valid/out_ready): one result
//   per decimal digit, least significant first, with digit_select giving
//   the latch index, bcd_digit the code for the data lines and last set on
//   the final digit of the value.
//   configuration channel (cfg_valid/cfg_ready, cfg_data): digit count,
//   always ready; zero acts as one, values above ten act as ten. write it
//   only while no value is in flight. reset value is three.
// sequence
//   each digit is formed by ST_MUL then ST_EMIT: ST_MUL registers rest *
//   reciprocal of ten from the 32x32 multiplier, ST_EMIT forms quotient and
//   remainder and loads the output register. after the last digit the
//   controller returns to idle and the next request can be taken.
// stall
//   the output register holds a digit until taken; while it is full and
//   out_ready is low the controller waits to emit the next digit. a new
//   request can be taken while the last digit waits in the output register.
// reset
//   asynchronous, active low: controller idle, output empty, count = 3.

module binary_to_bcd_digit_driver_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [bbcd_pkg::VALUE_W-1:0] value,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [bbcd_pkg::COUNT_W-1:0]      digit_select,
    output logic [bbcd_pkg::DIGIT_W-1:0]      bcd_digit,
    output logic                              last,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [bbcd_pkg::COUNT_W-1:0] cfg_data
);

    bbcd_pkg::dp_cmd_t    cmd;
    bbcd_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    bbcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bbcd_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .digit_select (digit_select),
        .bcd_digit    (bcd_digit),
        .last         (last)
    );

    // a taken request always starts at least one digit of work
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted but controller did not leave idle");

    // the latch index never reaches the maximum digit count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (digit_select < bbcd_pkg::MAX_DIGITS))
        else $error("digit index out of range");

    // a non-final digit leaves the controller busy with the same value
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> !in_ready)
        else $error("controller idle while digits of a value remain");

    // a bcd code is always a decimal digit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (bcd_digit <= 4'd9))
        else $error("bcd code above nine");

endmodule

`default_nettype wire
